// File: rtl/rgb_to_hsv_converter_macros.svh
// Assertion macros shared by the RGB to HSV converter RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter check failed");
// Next-cycle implication, checked out of reset.
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter check failed");
`else
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/rhc_pkg.sv
// Types and constants of the RGB to HSV converter.
// No dependencies; used by rhc_front, rhc_div_stage and the top level.
package rhc_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int QUOT_W     = 16;
  localparam int HUE_REM_W  = 11;  // 6*delta <= 1530
  localparam int SAT_REM_W  = CHAN_W;
  localparam int DIV_STEPS  = 4;   // quotient bits per divider stage
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
  localparam int OUT_DATA_W = 2 * QUOT_W + CHAN_W;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // After max/min search.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] max_val;
    logic [CHAN_W-1:0] delta;
    sector_t           sector;
  } chan_t;

  // Two restoring divisions in flight plus forcing flags.
  typedef struct packed {
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE_REM_W-1:0] hue_den;
    logic [QUOT_W-1:0]    hue_q;
    logic [SAT_REM_W-1:0] sat_rem;
    logic [SAT_REM_W-1:0] sat_den;
    logic [QUOT_W-1:0]    sat_q;
    logic [CHAN_W-1:0]    bright;
    logic                 hue_zero;
    logic                 sat_zero;
    logic                 sat_full;
  } div_t;

endpackage

// File: rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, divider slices and
// output register. Depends on rhc_pkg, rhc_front and rhc_div_stage.
//
// Usage:
//   Input channel in_*: one packed pixel per beat, red in tdata[23:16],
//   green in [15:8], blue in [7:0]. A beat is taken when in_tvalid and
//   in_tready are both high.
//   Output channel out_*: one result beat per input beat, in order:
//   hue as a 0.16 fraction of a turn, saturation as a 0.16 fraction
//   (saturated at 65535) and brightness (the largest channel).
//   Pipeline: max/min stage, numerator stage, four divider slices of four
//   quotient bits each, output register. Throughput is one pixel per
//   cycle while out_tready is high, set by the per-stage registers of
//   the two 16-bit restoring dividers.
//   Each stage has its own valid bit and holds its beat while the next
//   stage is full, so gaps close up under stall and in_tready drops only
//   when all seven stages are occupied and out_tready is low.
//   Reset (rst_n low at a clock edge) empties every stage; no beat is
//   lost or repeated across a stall.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rhc_pkg::PIXEL_W-1:0]    in_tdata,   // pixel_rgb[23:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hue_turn[15:0], saturation_frac[31:16], brightness_level[39:32]
  output logic [rhc_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic          div_valid [rhc_pkg::DIV_STAGES+1];
  logic          div_ready [rhc_pkg::DIV_STAGES+1];
  rhc_pkg::div_t div_data  [rhc_pkg::DIV_STAGES+1];

  logic                           out_valid_r;
  logic [rhc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [rhc_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic                           last_ready;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  for (genvar s = 0; s < rhc_pkg::DIV_STAGES; s++) begin : g_div
    rhc_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_data   (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  // Special cases: grey gives hue 0, black gives saturation 0,
  // delta equal to a nonzero max gives full-scale saturation.
  always_comb begin
    logic [rhc_pkg::QUOT_W-1:0] hue;
    logic [rhc_pkg::QUOT_W-1:0] sat;
    hue = div_data[rhc_pkg::DIV_STAGES].hue_zero ? '0 : div_data[rhc_pkg::DIV_STAGES].hue_q;
    priority if (div_data[rhc_pkg::DIV_STAGES].sat_zero) begin
      sat = '0;
    end else if (div_data[rhc_pkg::DIV_STAGES].sat_full) begin
      sat = '1;
    end else begin
      sat = div_data[rhc_pkg::DIV_STAGES].sat_q;
    end
    out_data_nxt = {div_data[rhc_pkg::DIV_STAGES].bright, sat, hue};
  end

  assign last_ready                     = !out_valid_r || out_tready;
  assign div_ready[rhc_pkg::DIV_STAGES] = last_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= div_valid[rhc_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && div_valid[rhc_pkg::DIV_STAGES]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `RHC_ASSERT_IMP(a_black_all_zero, clk, rst_n, out_tvalid && (out_tdata[39:32] == 8'd0), out_tdata[31:0] == 32'd0)
  `RHC_ASSERT_IMP(a_grey_hue_zero, clk, rst_n, out_tvalid && (out_tdata[31:16] == 16'd0), out_tdata[15:0] == 16'd0)
  `RHC_ASSERT_IMP(a_full_only_on_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready)

endmodule

// File: rtl/rhc_front.sv
// Front end of the converter: channel max/min search, then hue numerator
// and divider setup. Two register stages. Depends on rhc_pkg.
module rhc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rhc_pkg::PIXEL_W-1:0] in_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rhc_pkg::div_t               out_data
);

  logic           a_valid_r;
  rhc_pkg::chan_t a_data_r;
  rhc_pkg::chan_t a_nxt;
  logic           a_ready;
  logic           b_valid_r;
  rhc_pkg::div_t  b_data_r;
  rhc_pkg::div_t  b_nxt;
  logic           b_ready;

  // Stage A: max, min, sector (red wins ties, then green).
  always_comb begin
    logic [rhc_pkg::CHAN_W-1:0] r;
    logic [rhc_pkg::CHAN_W-1:0] g;
    logic [rhc_pkg::CHAN_W-1:0] b;
    logic [rhc_pkg::CHAN_W-1:0] mx;
    logic [rhc_pkg::CHAN_W-1:0] mn;
    r  = in_pixel[3*rhc_pkg::CHAN_W-1:2*rhc_pkg::CHAN_W];
    g  = in_pixel[2*rhc_pkg::CHAN_W-1:rhc_pkg::CHAN_W];
    b  = in_pixel[rhc_pkg::CHAN_W-1:0];
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    a_nxt.red     = r;
    a_nxt.green   = g;
    a_nxt.blue    = b;
    a_nxt.max_val = mx;
    a_nxt.delta   = mx - mn;
    if (mx == r) begin
      a_nxt.sector = rhc_pkg::SECT_RED;
    end else if (mx == g) begin
      a_nxt.sector = rhc_pkg::SECT_GREEN;
    end else begin
      a_nxt.sector = rhc_pkg::SECT_BLUE;
    end
  end

  // Stage B: numerator in sixths of a turn, scaled by delta.
  always_comb begin
    logic [rhc_pkg::HUE_REM_W-1:0] d;
    logic [rhc_pkg::HUE_REM_W-1:0] d6;
    logic [rhc_pkg::HUE_REM_W-1:0] r;
    logic [rhc_pkg::HUE_REM_W-1:0] g;
    logic [rhc_pkg::HUE_REM_W-1:0] b;
    logic [rhc_pkg::HUE_REM_W-1:0] num;
    d  = rhc_pkg::HUE_REM_W'(a_data_r.delta);
    r  = rhc_pkg::HUE_REM_W'(a_data_r.red);
    g  = rhc_pkg::HUE_REM_W'(a_data_r.green);
    b  = rhc_pkg::HUE_REM_W'(a_data_r.blue);
    d6 = (d << 2) + (d << 1);
    unique case (a_data_r.sector)
      rhc_pkg::SECT_RED:   num = (g >= b) ? (g - b) : (d6 - (b - g));
      rhc_pkg::SECT_GREEN: num = (d << 1) + b - r;
      rhc_pkg::SECT_BLUE:  num = (d << 2) + r - g;
      default:             num = '0;
    endcase
    b_nxt.hue_rem  = num;
    b_nxt.hue_den  = d6;
    b_nxt.hue_q    = '0;
    // delta == max gives a quotient of exactly one: forced to full scale later
    b_nxt.sat_rem  = (a_data_r.delta == a_data_r.max_val) ? '0 : a_data_r.delta;
    b_nxt.sat_den  = a_data_r.max_val;
    b_nxt.sat_q    = '0;
    b_nxt.bright   = a_data_r.max_val;
    b_nxt.hue_zero = (a_data_r.delta == '0);
    b_nxt.sat_zero = (a_data_r.max_val == '0);
    b_nxt.sat_full = (a_data_r.delta == a_data_r.max_val);
  end

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_data_r <= a_nxt;
    end
    if (b_ready && a_valid_r) begin
      b_data_r <= b_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

// File: rtl/rhc_div_stage.sv
// One slice of the two restoring dividers (hue and saturation),
// DIV_STEPS quotient bits per slice, one register stage. Depends on rhc_pkg.
`include "rgb_to_hsv_converter_macros.svh"

module rhc_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rhc_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rhc_pkg::div_t out_data
);

  logic          valid_r;
  rhc_pkg::div_t data_r;
  rhc_pkg::div_t data_nxt;

  // Remainder stays below the divisor, so the doubled value fits one extra bit.
  always_comb begin
    logic [rhc_pkg::HUE_REM_W:0] h_t;
    logic [rhc_pkg::SAT_REM_W:0] s_t;
    data_nxt = in_data;
    for (int i = 0; i < rhc_pkg::DIV_STEPS; i++) begin
      h_t = {data_nxt.hue_rem, 1'b0};
      if (h_t >= {1'b0, data_nxt.hue_den}) begin
        h_t = h_t - {1'b0, data_nxt.hue_den};
        data_nxt.hue_q = {data_nxt.hue_q[rhc_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        data_nxt.hue_q = {data_nxt.hue_q[rhc_pkg::QUOT_W-2:0], 1'b0};
      end
      data_nxt.hue_rem = h_t[rhc_pkg::HUE_REM_W-1:0];

      s_t = {data_nxt.sat_rem, 1'b0};
      if (s_t >= {1'b0, data_nxt.sat_den}) begin
        s_t = s_t - {1'b0, data_nxt.sat_den};
        data_nxt.sat_q = {data_nxt.sat_q[rhc_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        data_nxt.sat_q = {data_nxt.sat_q[rhc_pkg::QUOT_W-2:0], 1'b0};
      end
      data_nxt.sat_rem = s_t[rhc_pkg::SAT_REM_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `RHC_ASSERT_IMP(a_hue_rem_bound, clk, rst_n, valid_r && !data_r.hue_zero, data_r.hue_rem < data_r.hue_den)
  `RHC_ASSERT_IMP(a_sat_rem_bound, clk, rst_n, valid_r && !data_r.sat_zero && !data_r.sat_full, data_r.sat_rem < data_r.sat_den)
  `RHC_ASSERT_NXT(a_hold_on_stall, clk, rst_n, valid_r && !out_ready, valid_r)

endmodule
